// ----- src/b2r_pkg.sv -----
// shared types and constants for the binary to radix digit converter
`timescale 1ns / 1ps
package b2r_pkg;

  // value width and depth of the digit store
  localparam int VALUE_BITS = 31;
  localparam int MAX_DIGITS = 32;
  localparam int BASE_W     = 5;
  localparam int DIGIT_W    = 4;
  localparam int ADDR_W     = $clog2(MAX_DIGITS);
  localparam int CNT_W      = $clog2(MAX_DIGITS + 1);
  localparam int BIT_W      = $clog2(VALUE_BITS);

  // radix limits
  localparam logic [BASE_W-1:0] BASE_MIN = BASE_W'(2);
  localparam logic [BASE_W-1:0] BASE_MAX = BASE_W'(16);

  typedef struct packed {
    logic [VALUE_BITS-1:0] value;
    logic [BASE_W-1:0]     base;
  } b2r_in_t;

  typedef struct packed {
    logic [DIGIT_W-1:0] digit;
    logic               last;
  } b2r_out_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_STORE,
    S_READ,
    S_LOAD,
    S_SEND
  } b2r_state_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic div_step;
    logic store;
    logic rd;
    logic out_load;
    logic next_digit;
  } b2r_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic div_last;
    logic val_zero;
    logic store_full;
    logic k_zero;
  } b2r_sts_t;

endpackage

// ----- src/b2r_ram.sv -----
// generic single-port-write ram with registered read
`timescale 1ns / 1ps
module b2r_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- src/b2r_dpath.sv -----
// datapath: bit-serial divider, digit store and output register
`timescale 1ns / 1ps
module b2r_dpath (
  input  logic              clk,
  input  logic              rst,
  input  b2r_pkg::b2r_in_t  in_data,
  input  b2r_pkg::b2r_cmd_t cmd,
  output b2r_pkg::b2r_sts_t sts,
  output b2r_pkg::b2r_out_t out_data
);
  import b2r_pkg::*;

  logic [VALUE_BITS-1:0] val;
  logic [DIGIT_W-1:0]    rem;
  logic [BASE_W-1:0]     base;
  logic [BIT_W-1:0]      bit_cnt;
  logic [CNT_W-1:0]      digit_count;
  logic [CNT_W-1:0]      k;
  logic [DIGIT_W-1:0]    rd_data;

  logic [BASE_W-1:0]     base_clamped;
  logic [BASE_W-1:0]     trial;
  logic [BASE_W-1:0]     diff;
  logic                  ge;

  // radix clamp to two through sixteen
  always_comb begin
    if (in_data.base < BASE_MIN) begin
      base_clamped = BASE_MIN;
    end else if (in_data.base > BASE_MAX) begin
      base_clamped = BASE_MAX;
    end else begin
      base_clamped = in_data.base;
    end
  end

  // one restoring division step
  assign trial = {rem, val[VALUE_BITS-1]};
  assign ge    = (trial >= base);
  assign diff  = trial - base;

  // divider registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      val  <= in_data.value;
      base <= base_clamped;
      rem  <= '0;
    end else if (cmd.div_step) begin
      val <= {val[VALUE_BITS-2:0], ge};
      rem <= ge ? diff[DIGIT_W-1:0] : trial[DIGIT_W-1:0];
    end else if (cmd.store) begin
      rem <= '0;
    end
  end

  // counters
  always_ff @(posedge clk) begin
    if (rst) begin
      bit_cnt     <= '0;
      digit_count <= '0;
      k           <= '0;
    end else begin
      if (cmd.load) begin
        bit_cnt     <= '0;
        digit_count <= '0;
      end else if (cmd.div_step) begin
        bit_cnt <= bit_cnt + BIT_W'(1);
      end else if (cmd.store) begin
        bit_cnt     <= '0;
        digit_count <= digit_count + CNT_W'(1);
      end
      if (cmd.store) begin
        k <= digit_count;
      end else if (cmd.next_digit) begin
        k <= k - CNT_W'(1);
      end
    end
  end

  // digit store, least significant digit first
  b2r_ram #(
    .WIDTH(DIGIT_W),
    .DEPTH(MAX_DIGITS)
  ) u_store (
    .clk    (clk),
    .wr_en  (cmd.store),
    .wr_addr(digit_count[ADDR_W-1:0]),
    .wr_data(rem),
    .rd_en  (cmd.rd),
    .rd_addr(k[ADDR_W-1:0]),
    .rd_data(rd_data)
  );

  // output register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data.digit <= rd_data;
      out_data.last  <= (k == '0);
    end
  end

  // status
  assign sts.div_last   = (bit_cnt == BIT_W'(VALUE_BITS - 1));
  assign sts.val_zero   = (val == '0);
  assign sts.store_full = (digit_count == CNT_W'(MAX_DIGITS - 1));
  assign sts.k_zero     = (k == '0);

endmodule

// ----- src/b2r_ctrl.sv -----
// controller: sequences division, digit store and digit emission
`timescale 1ns / 1ps
module b2r_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  input  b2r_pkg::b2r_sts_t sts,
  output b2r_pkg::b2r_cmd_t cmd
);
  import b2r_pkg::*;

  b2r_state_t state;
  b2r_state_t state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) state_next = S_DIV;
      end
      S_DIV: begin
        if (sts.div_last) state_next = S_STORE;
      end
      S_STORE: begin
        if (sts.val_zero || sts.store_full) begin
          state_next = S_READ;
        end else begin
          state_next = S_DIV;
        end
      end
      S_READ: state_next = S_LOAD;
      S_LOAD: state_next = S_SEND;
      S_SEND: begin
        if (!out_stall) begin
          state_next = sts.k_zero ? S_IDLE : S_READ;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd       = '0;
    in_stall  = 1'b1;
    out_valid = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_stall = 1'b0;
        cmd.load = in_valid;
      end
      S_DIV:   cmd.div_step = 1'b1;
      S_STORE: cmd.store = 1'b1;
      S_READ:  cmd.rd = 1'b1;
      S_LOAD:  cmd.out_load = 1'b1;
      S_SEND: begin
        out_valid      = 1'b1;
        cmd.next_digit = !out_stall && !sts.k_zero;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

// ----- src/binary_to_radix_digits.sv -----
// Converts a 31-bit integer to radix 2..16 digits, most significant first.
// Each digit takes 31 steps of the bit-serial divider plus one store.
// A value of D digits is divided in full, then each digit goes through store read,
// output load and send, where send waits out any output stall; one transaction at a
// time: no new item is taken before the final digit. Reset is synchronous: it
// returns the controller to idle and clears the counters, not the digit store.
`timescale 1ns / 1ps
module binary_to_radix_digits (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  b2r_pkg::b2r_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output b2r_pkg::b2r_out_t out_data
);
  import b2r_pkg::*;

  b2r_cmd_t cmd;
  b2r_sts_t sts;

  // control
  b2r_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // datapath
  b2r_dpath u_dpath (
    .clk     (clk),
    .rst     (rst),
    .in_data (in_data),
    .cmd     (cmd),
    .sts     (sts),
    .out_data(out_data)
  );

  // no new input while a digit is being offered
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall)
    else $error("input taken while a digit is pending");

  // final digit ends the transaction
  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && out_data.last |=> !out_valid && !in_stall)
    else $error("converter not idle after final digit");

  // a taken digit that is not final is followed by a refetch gap
  a_refetch_gap: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && !out_data.last |=> !out_valid && in_stall)
    else $error("next digit offered without store read");

  // an accepted item starts the divider
  a_start_div: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall && !out_valid)
    else $error("accepted item did not start division");

endmodule
